FILE: src/mpbm_pkg.sv
// Package for the multi-pattern byte matcher.
// Holds the controller state type, command codes and ASCII case helpers.
// No dependencies.
package mpbm_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_EVAL1,
        S_EVAL2,
        S_ROWRD,
        S_ROWQ,
        S_EMIT
    } t_state;

    localparam logic [2:0] CMD_EDGE    = 3'd0;
    localparam logic [2:0] CMD_FAIL    = 3'd1;
    localparam logic [2:0] CMD_SLOT    = 3'd2;
    localparam logic [2:0] CMD_SCAN    = 3'd3;
    localparam logic [2:0] CMD_RESTART = 3'd4;

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        upper_of = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        lower_of = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

endpackage

FILE: src/multi_pattern_byte_matcher.sv
// Top level of the multi-pattern byte matcher (Aho-Corasick automaton).
// Depends on mpbm_pkg. Goto, failure and match-slot tables are local memories.
//
// Usage:
//   A transaction is taken when start is high and busy is low. Commands write
//   a goto edge, a failure link or a match slot, restart the scan or scan one
//   text byte; other command codes are ignored.
//   A scan looks up the goto edge (with case folding, a second lower-case
//   lookup follows a miss), repeats this for every failure hop, then
//   fetches the match row and emits its results one per cycle. The
//   failure-hop loop goes through the goto memory's single read port.
//   Results appear for exactly one cycle with o_valid; o_last marks the final
//   match of the byte. The receiver cannot stall; results are never held.
//   fold_case is written through i_cfg_we / i_cfg_wdata; the user must do so
//   only while idle, as the block does not enforce it. After reset a
//   clearing pass over all NODE_COUNT*256 goto entries zeroes all tables;
//   busy stays high through it. Position counter and current state clear.
module multi_pattern_byte_matcher
    import mpbm_pkg::*;
#(
    parameter int NODE_COUNT     = 256,
    parameter int SLOTS_PER_NODE = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_node,
    input  logic [7:0]  i_symbol,
    input  logic [7:0]  i_target_node,
    input  logic [2:0]  i_slot,
    input  logic [7:0]  i_pattern_length,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_valid,
    output logic [31:0] o_end_position,
    output logic [7:0]  o_match_length,
    output logic        o_last
);

    localparam int NODE_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int GA_W       = NODE_W + 8;
    localparam int GOTO_DEPTH = NODE_COUNT * 256;
    localparam int SLOT_W     = (SLOTS_PER_NODE > 1) ? $clog2(SLOTS_PER_NODE) : 1;
    localparam int LANES      = (SLOTS_PER_NODE < 8) ? SLOTS_PER_NODE : 8;
    localparam int ROW_W      = SLOTS_PER_NODE * 8;
    localparam int LIDX_W     = (LANES > 1) ? $clog2(LANES) : 1;

    function automatic logic [NODE_W-1:0] node_of(input logic [7:0] v);
        logic [16:0] r;
        logic [16:0] d;
        r = {9'd0, v};
        if (NODE_COUNT < 256) begin
            for (int i = 7; i >= 0; i--) begin
                d = 17'(NODE_COUNT) << i;
                if (r >= d) begin
                    r = r - d;
                end
            end
        end
        node_of = NODE_W'(r);
    endfunction

    // Tables
    logic [7:0]       r_goto_mem [GOTO_DEPTH];
    logic [7:0]       r_fail_mem [NODE_COUNT];
    logic [ROW_W-1:0] r_slot_mem [NODE_COUNT];

    logic [7:0]       r_goto_q;
    logic [7:0]       r_fail_q;
    logic [ROW_W-1:0] r_row_q;

    t_state              r_state, n_state;
    logic [GA_W-1:0]     r_clr, n_clr;
    logic [NODE_W-1:0]   r_cur, n_cur;
    logic [NODE_W:0]     r_hops, n_hops;
    logic [31:0]         r_cnt, n_cnt;
    logic [31:0]         r_pos, n_pos;
    logic [7:0]          r_sym, n_sym;
    logic [LANES-1:0]    r_mask, n_mask;
    logic                r_fold, n_fold;

    logic                accept;
    logic                goto_re, fail_re, row_re;
    logic [GA_W-1:0]     goto_raddr;
    logic [7:0]          c1, c2;
    logic [LANES-1:0]    row_mask;
    logic [LIDX_W-1:0]   lane_idx;
    logic                miss;
    logic [6:0]          slot7;
    logic [NODE_W-1:0]   wr_node;

    assign accept  = start && !busy;
    assign c1      = r_fold ? upper_of(r_sym) : r_sym;
    assign c2      = lower_of(r_sym);
    assign slot7   = {4'd0, i_slot};
    assign wr_node = node_of(i_node);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            row_mask[i] = (r_row_q[i*8 +: 8] != 8'd0);
        end
        lane_idx = '0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                lane_idx = LIDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cur      = r_cur;
        n_hops     = r_hops;
        n_cnt      = r_cnt;
        n_pos      = r_pos;
        n_sym      = r_sym;
        n_mask     = r_mask;
        n_fold     = i_cfg_we ? i_cfg_wdata : r_fold;
        goto_re    = 1'b0;
        fail_re    = 1'b0;
        row_re     = 1'b0;
        goto_raddr = {r_cur, c1};
        miss       = 1'b0;
        busy       = 1'b1;
        o_valid    = 1'b0;
        o_last     = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == GA_W'(GOTO_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                busy = 1'b0;
                if (accept) begin
                    case (i_command)
                        CMD_SCAN: begin
                            n_sym   = i_symbol;
                            n_pos   = r_cnt;
                            n_cnt   = r_cnt + 32'd1;
                            n_hops  = '0;
                            n_state = S_ISSUE;
                        end
                        CMD_RESTART: begin
                            n_cur = '0;
                            n_cnt = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                goto_re = 1'b1;
                fail_re = 1'b1;
                n_state = S_EVAL1;
            end
            S_EVAL1: begin
                if (r_goto_q != 8'd0) begin
                    n_cur   = node_of(r_goto_q);
                    n_state = S_ROWRD;
                end else if (r_fold) begin
                    goto_raddr = {r_cur, c2};
                    goto_re    = 1'b1;
                    n_state    = S_EVAL2;
                end else begin
                    miss = 1'b1;
                end
            end
            S_EVAL2: begin
                if (r_goto_q != 8'd0) begin
                    n_cur   = node_of(r_goto_q);
                    n_state = S_ROWRD;
                end else begin
                    miss = 1'b1;
                end
            end
            S_ROWRD: begin
                row_re  = 1'b1;
                n_state = S_ROWQ;
            end
            S_ROWQ: begin
                n_mask  = row_mask;
                n_state = (row_mask == '0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                o_valid = 1'b1;
                n_mask  = r_mask & (r_mask - 1'b1);
                o_last  = (n_mask == '0);
                if (o_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // No edge: hop along the failure link, fall back to the root once
        // the hop budget is spent, or stay at the root.
        if (miss) begin
            if (r_cur != '0 && r_hops < (NODE_W+1)'(NODE_COUNT)) begin
                n_cur   = node_of(r_fail_q);
                n_hops  = r_hops + 1'b1;
                n_state = S_ISSUE;
            end else if (r_cur != '0) begin
                n_cur   = '0;
                n_state = S_ISSUE;
            end else begin
                n_state = S_ROWRD;
            end
        end
    end

    assign o_end_position = r_pos;
    assign o_match_length = r_row_q[8*lane_idx +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cur   <= '0;
            r_hops  <= '0;
            r_cnt   <= '0;
            r_mask  <= '0;
            r_fold  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_cur   <= n_cur;
            r_hops  <= n_hops;
            r_cnt   <= n_cnt;
            r_mask  <= n_mask;
            r_fold  <= n_fold;
        end
        r_pos <= n_pos;
        r_sym <= n_sym;
    end

    // Memory ports: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_goto_mem[r_clr] <= 8'd0;
            r_fail_mem[r_clr[GA_W-1:8]] <= 8'd0;
            r_slot_mem[r_clr[GA_W-1:8]] <= '0;
        end else if (accept) begin
            case (i_command)
                CMD_EDGE: r_goto_mem[{wr_node, i_symbol}] <= i_target_node;
                CMD_FAIL: r_fail_mem[wr_node] <= i_target_node;
                CMD_SLOT: begin
                    if (slot7 < 7'(SLOTS_PER_NODE)) begin
                        r_slot_mem[wr_node][8*slot7[SLOT_W-1:0] +: 8] <= i_pattern_length;
                    end
                end
                default: ;
            endcase
        end
        if (goto_re) begin
            r_goto_q <= r_goto_mem[goto_raddr];
        end
        if (fail_re) begin
            r_fail_q <= r_fail_mem[r_cur];
        end
        if (row_re) begin
            r_row_q <= r_slot_mem[r_cur];
        end
    end

`ifndef ASSERT_OFF
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe while not busy");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result after final match of byte");
    a_burst_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("match burst broken before last");
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_match_length != 8'd0))
        else $error("empty slot reported");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for multi_pattern_byte_matcher: loads small automata, scans text
// and checks every match against an internal Aho-Corasick predictor.
// Depends on mpbm_pkg and the matcher RTL.
module tb;
    import mpbm_pkg::*;

    localparam int NODES = 256;
    localparam int SLOTS = 8;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] node;
        logic [7:0] symbol;
        logic [7:0] target;
        logic [2:0] slot;
        logic [7:0] plen;
    } t_txn;

    typedef struct packed {
        logic [31:0] pos;
        logic [7:0]  len;
        logic        last;
    } t_match;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_command = '0;
    logic [7:0]  i_node = '0;
    logic [7:0]  i_symbol = '0;
    logic [7:0]  i_target_node = '0;
    logic [2:0]  i_slot = '0;
    logic [7:0]  i_pattern_length = '0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        o_valid;
    logic [31:0] o_end_position;
    logic [7:0]  o_match_length;
    logic        o_last;

    multi_pattern_byte_matcher u_top (
        .i_clk, .i_rst_n, .start, .busy, .i_command, .i_node, .i_symbol,
        .i_target_node, .i_slot, .i_pattern_length, .i_cfg_we, .i_cfg_wdata,
        .o_valid, .o_end_position, .o_match_length, .o_last
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  goto_mem [NODES*256];
    logic [7:0]  fail_mem [NODES];
    logic [7:0]  slot_mem [NODES*SLOTS];
    logic [7:0]  cur_node;
    logic [31:0] byte_pos;
    logic        fold;

    t_txn   pending_txns[$];
    t_match expected_matches[$];
    int     errors = 0;
    int     sent = 0;
    int     queued = 0;
    longint cycles = 0;
    int     gap = 0;

    function automatic logic [7:0] lookup_edge(logic [7:0] n, logic [7:0] c);
        logic [7:0] t;
        if (fold) begin
            t = goto_mem[{n, (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c}];
            if (t == 0) t = goto_mem[{n, (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c}];
        end else begin
            t = goto_mem[{n, c}];
        end
        return t;
    endfunction

    task automatic predict_matches(t_txn x);
        logic [7:0] t;
        int hops;
        int first;
        t_match m;
        case (x.cmd)
            CMD_EDGE: goto_mem[{x.node, x.symbol}] = x.target;
            CMD_FAIL: fail_mem[x.node] = x.target;
            CMD_SLOT: slot_mem[{x.node, x.slot}] = x.plen;
            CMD_RESTART: begin
                cur_node = 0;
                byte_pos = 0;
            end
            CMD_SCAN: begin
                t = lookup_edge(cur_node, x.symbol);
                hops = 0;
                while (t == 0 && cur_node != 0 && hops < NODES) begin
                    cur_node = fail_mem[cur_node];
                    t = lookup_edge(cur_node, x.symbol);
                    hops++;
                end
                if (t == 0 && cur_node != 0) begin
                    cur_node = 0;
                    t = lookup_edge(0, x.symbol);
                end
                if (t != 0) cur_node = t;
                first = expected_matches.size();
                for (int s = 0; s < SLOTS; s++) begin
                    if (slot_mem[{cur_node, 3'(s)}] != 0) begin
                        m.pos  = byte_pos;
                        m.len  = slot_mem[{cur_node, 3'(s)}];
                        m.last = 1'b0;
                        expected_matches.insert(expected_matches.size(), m);
                    end
                end
                if (expected_matches.size() > first)
                    expected_matches[$].last = 1'b1;
                byte_pos++;
            end
            default: ;
        endcase
    endtask

    function automatic t_txn mk(logic [2:0] c, logic [7:0] n, logic [7:0] s,
                                logic [7:0] t, logic [2:0] sl, logic [7:0] l);
        return {c, n, s, t, sl, l};
    endfunction

    function automatic logic [7:0] rnd_text_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 8'(8'h41 + $urandom_range(0, 3) + (r < 3 ? 8'h20 : 8'h00));
        return 8'($urandom);
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (start && !busy) begin
            predict_matches({i_command, i_node, i_symbol, i_target_node, i_slot,
                             i_pattern_length});
            sent <= sent + 1;
        end
        if (i_rst_n && (!start || !busy)) begin
            if (gap > 0) begin
                gap <= gap - 1;
                start <= 1'b0;
            end else if (pending_txns.size() > 0) begin
                t_txn x;
                x = pending_txns[0];
                pending_txns.delete(0);
                start <= 1'b1;
                {i_command, i_node, i_symbol, i_target_node, i_slot,
                 i_pattern_length} <= x;
                gap <= ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 9) == 0 ?
                       $urandom_range(5, 30) : $urandom_range(1, 3)) : 0;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_matches.size() == 0) begin
                $display("%0t: unexpected match pos=%0d len=%0d last=%0b", $time,
                         o_end_position, o_match_length, o_last);
                errors++;
            end else begin
                t_match e;
                e = expected_matches[0];
                expected_matches.delete(0);
                if (e != {o_end_position, o_match_length, o_last}) begin
                    $display("%0t: exp pos=%0d len=%0d last=%0b got pos=%0d len=%0d last=%0b",
                             $time, e.pos, e.len, e.last, o_end_position, o_match_length,
                             o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic queue_txn(t_txn x);
        pending_txns.insert(pending_txns.size(), x);
        queued++;
    endtask

    task automatic drain();
        while (sent != queued || expected_matches.size() != 0 || busy || start)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_fold(logic v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fold = v;
    endtask

    // small random automaton over mostly letters, with failure links and match slots
    task automatic load_automaton(int nodes);
        for (int n = 0; n < nodes; n++) begin
            for (int k = 0; k < 2; k++)
                queue_txn(mk(CMD_EDGE, 8'(n), rnd_text_byte(),
                             8'($urandom_range(1, nodes)), 0, 0));
            queue_txn(mk(CMD_FAIL, 8'(n), 0, 8'($urandom_range(0, nodes)), 0, 0));
            if ($urandom_range(0, 1))
                queue_txn(mk(CMD_SLOT, 8'(n), 0, 0, 3'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        for (int i = 0; i < NODES*256; i++) goto_mem[i] = 0;
        for (int i = 0; i < NODES; i++) fail_mem[i] = 0;
        for (int i = 0; i < NODES*SLOTS; i++) slot_mem[i] = 0;
        cur_node = 0;
        byte_pos = 0;
        fold = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all commands, unused codes, root slots, a failure loop
        queue_txn(mk(CMD_SCAN, 0, 8'hFF, 0, 0, 0));
        queue_txn(mk(CMD_SLOT, 0, 0, 0, 3'd7, 8'hFF));
        queue_txn(mk(CMD_SCAN, 0, 8'h00, 0, 0, 0));
        queue_txn(mk(CMD_EDGE, 0, 8'h61, 8'd255, 0, 0));
        queue_txn(mk(CMD_EDGE, 8'd255, 8'hFF, 8'd1, 0, 0));
        for (int s = 0; s < 8; s++)
            queue_txn(mk(CMD_SLOT, 8'd1, 0, 0, 3'(s), (s == 3) ? 8'd0 : 8'(s + 1)));
        queue_txn(mk(CMD_SLOT, 8'd1, 0, 0, 3'd5, 8'd2));
        queue_txn(mk(CMD_FAIL, 8'd1, 0, 8'd255, 0, 0));
        queue_txn(mk(CMD_FAIL, 8'd255, 0, 8'd1, 0, 0));
        queue_txn(mk(CMD_SCAN, 0, 8'h61, 0, 0, 0));
        queue_txn(mk(CMD_SCAN, 0, 8'hFF, 0, 0, 0));
        queue_txn(mk(CMD_SCAN, 0, 8'h7A, 0, 0, 0));   // loops on failure cycle
        queue_txn(mk(3'd5, 8'hFF, 8'hFF, 8'hFF, 3'd7, 8'hFF));
        queue_txn(mk(3'd7, 0, 0, 0, 0, 0));
        queue_txn(mk(CMD_RESTART, 0, 0, 0, 0, 0));
        queue_txn(mk(CMD_SCAN, 0, 8'h61, 0, 0, 0));
        drain();
        set_fold(1'b1);
        queue_txn(mk(CMD_SCAN, 0, 8'h41, 0, 0, 0));
        queue_txn(mk(CMD_EDGE, 0, 8'h42, 8'd1, 0, 0));
        queue_txn(mk(CMD_SCAN, 0, 8'h62, 0, 0, 0));
        drain();

        // random phases with alternating case folding
        for (int ph = 0; ph < 4; ph++) begin
            set_fold(ph[0]);
            queue_txn(mk(CMD_RESTART, 0, 0, 0, 0, 0));
            load_automaton($urandom_range(3, 8));
            for (int i = 0; i < 40; i++) begin
                case ($urandom_range(0, 19))
                    0: queue_txn(mk(CMD_RESTART, 8'($urandom), 8'($urandom), 8'($urandom),
                                    3'($urandom), 8'($urandom)));
                    1: queue_txn(mk(3'($urandom_range(5, 7)), 8'($urandom), 8'($urandom),
                                    8'($urandom), 3'($urandom), 8'($urandom)));
                    2: queue_txn(mk(CMD_SLOT, 8'($urandom_range(0, 8)), 8'($urandom),
                                    8'($urandom), 3'($urandom), 8'($urandom)));
                    3: queue_txn(mk(CMD_FAIL, 8'($urandom), 8'($urandom), 8'($urandom),
                                    3'($urandom), 8'($urandom)));
                    default: queue_txn(mk(CMD_SCAN, 8'($urandom), rnd_text_byte(),
                                          8'($urandom), 3'($urandom), 8'($urandom)));
                endcase
            end
            drain();
        end
        set_fold(1'b0);
        drain();

        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
